// ===== design/i2cem_pkg.sv =====
// i2cem_pkg: shared types, phase codes and bus level tables for the
// i2c eeprom master. No dependencies; used by i2cem_core and i2c_eeprom_master.
package i2cem_pkg;

  // command kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [1:0] CFG_HALF_PER = 2'd1;
  localparam logic [1:0] CFG_SHORT_PH = 2'd2;

  // configuration reset values
  localparam logic [6:0]  DEV_ADDR_RST = 7'd80;
  localparam logic [15:0] HALF_PER_RST = 16'd250;
  localparam logic [15:0] SHORT_PH_RST = 16'd50;

  // bus phase codes
  localparam int unsigned PHASE_W = 4;
  localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ST_HIGH = 4'd1;
  localparam logic [PHASE_W-1:0] PH_ST_LOW  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_TX_LOW  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_TX_HIGH = 4'd4;
  localparam logic [PHASE_W-1:0] PH_AK_LOW  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_AK_HIGH = 4'd6;
  localparam logic [PHASE_W-1:0] PH_RS_LOW  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_RX_LOW  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_RX_HIGH = 4'd9;
  localparam logic [PHASE_W-1:0] PH_NK_LOW  = 4'd10;
  localparam logic [PHASE_W-1:0] PH_NK_HIGH = 4'd11;
  localparam logic [PHASE_W-1:0] PH_NK_END  = 4'd12;
  localparam logic [PHASE_W-1:0] PH_SP_LOW  = 4'd13;
  localparam logic [PHASE_W-1:0] PH_SP_HIGH = 4'd14;
  localparam logic [PHASE_W-1:0] PH_SP_END  = 4'd15;

  // per-phase levels, bit n belongs to phase code n
  localparam logic [15:0] SCL_LEVEL = 16'b1100_1010_0101_0111;
  localparam logic [15:0] SDA_LEVEL = 16'b1001_1111_1110_0011;
  localparam logic [15:0] LONG_PH   = 16'b1101_1110_0001_1110;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mem_address;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] half_period_ticks;
    logic [15:0] short_phase_ticks;
  } cfg_regs_t;

endpackage

// ===== design/i2cem_core.sv =====
// i2cem_core: bus sequencer state and its one-tick step logic.
// Depends on i2cem_pkg.
module i2cem_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  i2cem_pkg::in_item_t  item,
  input  i2cem_pkg::cfg_regs_t cfg,
  output i2cem_pkg::out_item_t result
);
  import i2cem_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        rd_r, rd_nxt;
  logic [7:0]  rx_byte_r, rx_byte_nxt;
  logic        ack_miss_r, ack_miss_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic        done;
  logic [15:0] len_raw, len_eff;
  logic        phase_end;
  logic [7:0]  rx_shift;

  // byte sent at a given position of the frame
  function automatic logic [7:0] frame_byte(input logic [1:0] idx, input logic [6:0] dev,
                                            input logic [7:0] addr, input logic [7:0] data,
                                            input logic rd);
    logic [7:0] dev_w;
    dev_w = {dev, 1'b0};
    if (idx == 2'd0) begin
      frame_byte = dev_w;
    end else if (idx == 2'd1) begin
      frame_byte = addr;
    end else begin
      frame_byte = rd ? {dev, 1'b1} : data;
    end
  endfunction

  // phase length and end of phase
  assign len_raw   = LONG_PH[phase_r] ? cfg.half_period_ticks : cfg.short_phase_ticks;
  assign len_eff   = (len_raw == 16'd0) ? 16'd1 : len_raw;
  assign phase_end = ({1'b0, tick_r} + 17'd1) >= {1'b0, len_eff};
  assign rx_shift  = {shift_r[6:0], item.sda_in};

  // one tick of the sequencer
  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    tick_nxt     = tick_r;
    shift_nxt    = shift_r;
    addr_nxt     = addr_r;
    data_nxt     = data_r;
    rd_nxt       = rd_r;
    rx_byte_nxt  = rx_byte_r;
    ack_miss_nxt = ack_miss_r;
    byte_idx_nxt = byte_idx_r;
    done         = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (item.kind == KIND_WRITE || item.kind == KIND_READ) begin
        addr_nxt     = item.mem_address;
        data_nxt     = item.write_data;
        rd_nxt       = (item.kind == KIND_READ);
        byte_idx_nxt = 2'd0;
        bit_cnt_nxt  = 3'd0;
        tick_nxt     = 16'd0;
        phase_nxt    = PH_ST_HIGH;
      end
    end else if (!phase_end) begin
      tick_nxt = tick_r + 16'd1;
    end else begin
      tick_nxt = 16'd0;
      unique case (phase_r)
        PH_ST_HIGH: phase_nxt = PH_ST_LOW;
        PH_ST_LOW: begin
          shift_nxt   = frame_byte(byte_idx_r, cfg.device_address, addr_r, data_r, rd_r);
          bit_cnt_nxt = 3'd0;
          phase_nxt   = PH_TX_LOW;
        end
        PH_TX_LOW: phase_nxt = PH_TX_HIGH;
        PH_TX_HIGH: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          if (bit_cnt_r == 3'd7) begin
            bit_cnt_nxt = 3'd0;
            phase_nxt   = PH_AK_LOW;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            phase_nxt   = PH_TX_LOW;
          end
        end
        PH_AK_LOW: phase_nxt = PH_AK_HIGH;
        PH_AK_HIGH: begin
          if (item.sda_in) ack_miss_nxt = 1'b1;
          // next byte, repeated start, read or stop
          if (!rd_r && byte_idx_r == 2'd3) begin
            phase_nxt = PH_SP_LOW;
          end else if (!rd_r && byte_idx_r == 2'd2) begin
            phase_nxt = PH_SP_LOW;
          end else if (byte_idx_r == 2'd0 || !rd_r) begin
            byte_idx_nxt = byte_idx_r + 2'd1;
            shift_nxt    = frame_byte(byte_idx_r + 2'd1, cfg.device_address,
                                      addr_r, data_r, rd_r);
            bit_cnt_nxt  = 3'd0;
            phase_nxt    = PH_TX_LOW;
          end else if (byte_idx_r == 2'd1) begin
            byte_idx_nxt = 2'd2;
            phase_nxt    = PH_RS_LOW;
          end else begin
            bit_cnt_nxt = 3'd0;
            shift_nxt   = 8'd0;
            phase_nxt   = PH_RX_LOW;
          end
        end
        PH_RS_LOW: phase_nxt = PH_ST_HIGH;
        PH_RX_LOW: phase_nxt = PH_RX_HIGH;
        PH_RX_HIGH: begin
          shift_nxt = rx_shift;
          if (bit_cnt_r == 3'd7) begin
            bit_cnt_nxt = 3'd0;
            rx_byte_nxt = rx_shift;
            phase_nxt   = PH_NK_LOW;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            phase_nxt   = PH_RX_LOW;
          end
        end
        PH_NK_LOW:  phase_nxt = PH_NK_HIGH;
        PH_NK_HIGH: phase_nxt = PH_NK_END;
        PH_NK_END:  phase_nxt = PH_SP_LOW;
        PH_SP_LOW:  phase_nxt = PH_SP_HIGH;
        PH_SP_HIGH: phase_nxt = PH_SP_END;
        PH_SP_END: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // result fields show the state after the tick
  always_comb begin
    result.scl_out   = SCL_LEVEL[phase_nxt];
    result.sda_out   = (phase_nxt == PH_TX_LOW || phase_nxt == PH_TX_HIGH) ?
                       shift_nxt[7] : SDA_LEVEL[phase_nxt];
    result.busy_res  = (phase_nxt != PH_IDLE);
    result.done_res  = done;
    result.read_data = rx_byte_nxt;
    result.ack_error = ack_miss_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= 3'd0;
      tick_r     <= 16'd0;
      shift_r    <= 8'd0;
      addr_r     <= 8'd0;
      data_r     <= 8'd0;
      rd_r       <= 1'b0;
      rx_byte_r  <= 8'd0;
      ack_miss_r <= 1'b0;
      byte_idx_r <= 2'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      tick_r     <= tick_nxt;
      shift_r    <= shift_nxt;
      addr_r     <= addr_nxt;
      data_r     <= data_nxt;
      rd_r       <= rd_nxt;
      rx_byte_r  <= rx_byte_nxt;
      ack_miss_r <= ack_miss_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
  end

endmodule

// ===== design/i2c_eeprom_master.sv =====
// i2c_eeprom_master: top level with config registers and a two-entry result buffer.
// Results are registered in the output stage, or the skid stage if it stays full.
// Throughput: one input beat per cycle while results are taken; the step logic
// is combinational and a skid stage holds one extra result.
// Reset: synchronous active low rst_n clears sequencer state and buffer valids
// and loads the config registers with their defaults.
// Depends on i2cem_pkg and i2cem_core.
module i2c_eeprom_master (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cem_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cem_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import i2cem_pkg::*;

  cfg_regs_t cfg_r;
  out_item_t step_res;
  out_item_t out_r;
  out_item_t skid_r;
  logic      out_valid_r;
  logic      skid_valid_r;
  logic      push;
  logic      pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address    <= DEV_ADDR_RST;
      cfg_r.half_period_ticks <= HALF_PER_RST;
      cfg_r.short_phase_ticks <= SHORT_PH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEV_ADDR: cfg_r.device_address    <= cfg_data[6:0];
        CFG_HALF_PER: cfg_r.half_period_ticks <= cfg_data;
        CFG_SHORT_PH: cfg_r.short_phase_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cem_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (push),
    .item    (in_item),
    .cfg     (cfg_r),
    .result  (step_res)
  );

  // output register plus skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // result beat payloads
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_r <= skid_r;
    end else if (!out_valid_r || pop) begin
      if (push) out_r <= step_res;
    end else if (push) begin
      skid_r <= step_res;
    end
  end

endmodule
